// ----- rtl/core/owbm_pkg.sv -----
`default_nettype none
package owbm_pkg;

    localparam int unsigned TimerW   = 10;
    localparam int unsigned SlotW    = 7;
    localparam int unsigned PollW    = 5;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 10;
    localparam int unsigned InDataW  = 16;
    localparam int unsigned OutDataW = 16;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PRESENCE = 2'd1,
        ST_NO_DEV   = 2'd2,
        ST_STUCK    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_PRES = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_REC   = 4'd5,
        PH_RD_LOW   = 4'd6,
        PH_RD_WAIT  = 4'd7,
        PH_RD_TAIL  = 4'd8
    } t_phase;

    typedef enum logic [CfgIdxW-1:0] {
        REG_RESET_LOW   = 3'd0,
        REG_WR_ONE_LOW  = 3'd1,
        REG_WR_ZERO_LOW = 3'd2,
        REG_SLOT_REC    = 3'd3,
        REG_RD_LOW      = 3'd4,
        REG_RD_SAMPLE   = 3'd5,
        REG_RD_TAIL     = 3'd6,
        REG_PRES_INTV   = 3'd7
    } t_reg_idx;

    localparam logic [TimerW-1:0] RstResetLow   = 10'd480;
    localparam logic [SlotW-1:0]  RstWrOneLow   = 7'd10;
    localparam logic [SlotW-1:0]  RstWrZeroLow  = 7'd65;
    localparam logic [SlotW-1:0]  RstSlotRec    = 7'd5;
    localparam logic [SlotW-1:0]  RstRdLow      = 7'd5;
    localparam logic [SlotW-1:0]  RstRdSample   = 7'd10;
    localparam logic [SlotW-1:0]  RstRdTail     = 7'd60;
    localparam logic [SlotW-1:0]  RstPresIntv   = 7'd30;

    // extra ticks after the first; a zero count still lasts one tick
    function automatic logic [TimerW-1:0] span(input logic [TimerW-1:0] n);
        span = (n == '0) ? '0 : n - 10'd1;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/one_wire_bus_master.sv -----
// Each accepted tick is a single registered phase step, and its result goes
// to the output register or the skid; one tick per clock while skid is empty.
// A two-entry output stage (output register plus skid) keeps input flowing
// while one result waits downstream.
// Reset (synchronous, active low): phase idle, counters and status zero,
// timing registers back to their default slot times.
`default_nettype none
module one_wire_bus_master #(
    parameter int unsigned RELEASE_POLLS      = 30,
    parameter int unsigned RELEASE_POLL_TICKS = 2,
    parameter int unsigned PRESENCE_SAMPLES   = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [owbm_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire logic [owbm_pkg::CfgDataW-1:0]    i_cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [1:0] command, [9:2] data_byte, [10] line_level, [15:11] zero
    input  wire logic [owbm_pkg::InDataW-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
    // [12:5] read_value, [15:13] zero
    output logic [owbm_pkg::OutDataW-1:0]         m_axis_tdata
);
    import owbm_pkg::*;

    // timing registers
    logic [TimerW-1:0] r_reset_low;
    logic [SlotW-1:0]  r_wr_one_low, r_wr_zero_low, r_slot_rec;
    logic [SlotW-1:0]  r_rd_low, r_rd_sample, r_rd_tail, r_pres_intv;

    // bus state
    t_phase            r_phase, n_phase;
    logic [TimerW-1:0] r_timer, n_timer;
    logic [3:0]        r_bit_idx, n_bit_idx;
    logic [7:0]        r_shift, n_shift;
    logic [PollW-1:0]  r_poll, n_poll;
    t_status           r_status, n_status;
    logic [7:0]        r_read_byte, n_read_byte;
    logic              w_done;

    // output stage
    logic                r_out_valid, r_skid_valid;
    logic [OutDataW-1:0] r_out_data, r_skid_data;
    logic [OutDataW-1:0] w_result;
    logic                w_in_acc, w_out_acc;

    t_cmd       w_cmd;
    logic [7:0] w_data;
    logic       w_line;

    assign w_cmd  = t_cmd'(s_axis_tdata[1:0]);
    assign w_data = s_axis_tdata[9:2];
    assign w_line = s_axis_tdata[10];

    assign s_axis_tready = !r_skid_valid;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low   <= RstResetLow;
            r_wr_one_low  <= RstWrOneLow;
            r_wr_zero_low <= RstWrZeroLow;
            r_slot_rec    <= RstSlotRec;
            r_rd_low      <= RstRdLow;
            r_rd_sample   <= RstRdSample;
            r_rd_tail     <= RstRdTail;
            r_pres_intv   <= RstPresIntv;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_RESET_LOW:   r_reset_low   <= i_cfg_data;
                REG_WR_ONE_LOW:  r_wr_one_low  <= i_cfg_data[SlotW-1:0];
                REG_WR_ZERO_LOW: r_wr_zero_low <= i_cfg_data[SlotW-1:0];
                REG_SLOT_REC:    r_slot_rec    <= i_cfg_data[SlotW-1:0];
                REG_RD_LOW:      r_rd_low      <= i_cfg_data[SlotW-1:0];
                REG_RD_SAMPLE:   r_rd_sample   <= i_cfg_data[SlotW-1:0];
                REG_RD_TAIL:     r_rd_tail     <= i_cfg_data[SlotW-1:0];
                REG_PRES_INTV:   r_pres_intv   <= i_cfg_data[SlotW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_bit_idx   <= '0;
            r_shift     <= '0;
            r_poll      <= '0;
            r_status    <= ST_OK;
            r_read_byte <= '0;
        end else if (w_in_acc) begin
            r_phase     <= n_phase;
            r_timer     <= n_timer;
            r_bit_idx   <= n_bit_idx;
            r_shift     <= n_shift;
            r_poll      <= n_poll;
            r_status    <= n_status;
            r_read_byte <= n_read_byte;
        end
    end

    always_comb begin
        logic [SlotW-1:0] wr_low;
        n_phase     = r_phase;
        n_timer     = r_timer;
        n_bit_idx   = r_bit_idx;
        n_shift     = r_shift;
        n_poll      = r_poll;
        n_status    = r_status;
        n_read_byte = r_read_byte;
        w_done      = 1'b0;
        wr_low      = '0;

        if (r_phase == PH_IDLE) begin
            case (w_cmd)
                CMD_RESET: begin
                    n_phase = PH_RST_LOW;
                    n_timer = span(r_reset_low);
                end
                CMD_WRITE: begin
                    n_shift   = w_data;
                    n_bit_idx = '0;
                    n_phase   = PH_WR_LOW;
                    wr_low    = w_data[0] ? r_wr_one_low : r_wr_zero_low;
                    n_timer   = span(TimerW'(wr_low));
                end
                CMD_READ: begin
                    n_shift   = '0;
                    n_bit_idx = '0;
                    n_phase   = PH_RD_LOW;
                    n_timer   = span(TimerW'(r_rd_low));
                end
                default: ;
            endcase
        end else if (r_timer != '0) begin
            n_timer = r_timer - 10'd1;
        end else begin
            case (r_phase)
                PH_RST_LOW: begin
                    n_phase = PH_RST_WAIT;
                    n_poll  = PollW'(RELEASE_POLLS);
                end
                PH_RST_WAIT: begin
                    if (w_line) begin
                        n_phase = PH_RST_PRES;
                        n_poll  = '0;
                    end else if (r_poll == '0) begin
                        n_phase  = PH_IDLE;
                        n_status = ST_STUCK;
                        w_done   = 1'b1;
                    end else begin
                        n_poll  = r_poll - 5'd1;
                        n_timer = TimerW'(RELEASE_POLL_TICKS - 1);
                    end
                end
                PH_RST_PRES: begin
                    if (r_poll >= PollW'(PRESENCE_SAMPLES)) begin
                        n_phase  = PH_IDLE;
                        n_status = ST_NO_DEV;
                        w_done   = 1'b1;
                    end else if (!w_line) begin
                        n_phase  = PH_IDLE;
                        n_status = ST_PRESENCE;
                        w_done   = 1'b1;
                    end else begin
                        n_poll  = r_poll + 5'd1;
                        n_timer = span(TimerW'(r_pres_intv));
                    end
                end
                PH_WR_LOW: begin
                    n_phase = PH_WR_REC;
                    n_timer = span(TimerW'(r_slot_rec));
                end
                PH_WR_REC: begin
                    n_bit_idx = r_bit_idx + 4'd1;
                    if (n_bit_idx[3]) begin
                        n_phase  = PH_IDLE;
                        n_status = ST_OK;
                        w_done   = 1'b1;
                    end else begin
                        n_phase = PH_WR_LOW;
                        wr_low  = r_shift[n_bit_idx[2:0]] ? r_wr_one_low : r_wr_zero_low;
                        n_timer = span(TimerW'(wr_low));
                    end
                end
                PH_RD_LOW: begin
                    n_phase = PH_RD_WAIT;
                    n_timer = span(TimerW'(r_rd_sample));
                end
                PH_RD_WAIT: begin
                    n_shift   = {w_line, r_shift[7:1]};
                    n_bit_idx = r_bit_idx + 4'd1;
                    n_phase   = PH_RD_TAIL;
                    n_timer   = span(TimerW'(r_rd_tail));
                end
                PH_RD_TAIL: begin
                    if (r_bit_idx[3]) begin
                        n_read_byte = r_shift;
                        n_phase     = PH_IDLE;
                        n_status    = ST_OK;
                        w_done      = 1'b1;
                    end else begin
                        n_phase = PH_RD_LOW;
                        n_timer = span(TimerW'(r_rd_low));
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_timer = '0;
                end
            endcase
        end
    end

    always_comb begin
        w_result       = '0;
        w_result[0]    = (n_phase == PH_RST_LOW) || (n_phase == PH_WR_LOW) ||
                         (n_phase == PH_RD_LOW);
        w_result[1]    = (n_phase != PH_IDLE);
        w_result[2]    = w_done;
        w_result[4:3]  = n_status;
        w_result[12:5] = n_read_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_acc || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_in_acc;
            end
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_acc || !r_out_valid) begin
            r_out_data <= r_skid_valid ? r_skid_data : w_result;
        end
        if (!(w_out_acc || !r_out_valid) && w_in_acc) begin
            r_skid_data <= w_result;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (n_phase == PH_IDLE))
        else $error("command finished but phase not idle");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("line driven low while not busy");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !m_axis_tready |=> r_skid_valid && $stable(r_skid_data))
        else $error("skid entry lost while output stalled");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WR_LOW) || (r_phase == PH_RD_LOW) |-> !r_bit_idx[3])
        else $error("slot started past the last bit");

endmodule
`default_nettype wire

// ----- tb/tb_one_wire_bus_master.sv -----
module tb_one_wire_bus_master;
    timeunit 1ns;
    timeprecision 1ps;

    import owbm_pkg::*;

    localparam int RELEASE_POLLS      = 30;
    localparam int RELEASE_POLL_TICKS = 2;
    localparam int PRESENCE_SAMPLES   = 16;
    localparam int CYCLE_LIMIT        = 3_000_000;

    // one result per tick, as laid out on m_axis_tdata (lowest field last)
    typedef struct packed {
        logic [2:0] pad;
        logic [7:0] rd;
        t_status    st;
        logic       done;
        logic       busy;
        logic       drive;
    } owire_res_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // [1:0] command, [9:2] data_byte, [10] line_level, [15:11] zero
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b1;
    // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
    // [12:5] read_value, [15:13] zero
    logic [OutDataW-1:0] m_axis_tdata;

    one_wire_bus_master #(
        .RELEASE_POLLS      (RELEASE_POLLS),
        .RELEASE_POLL_TICKS (RELEASE_POLL_TICKS),
        .PRESENCE_SAMPLES   (PRESENCE_SAMPLES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // bus master shadow state
    logic [7:0][9:0] tcfg;
    t_phase          ph;
    logic [9:0]      tmr;
    logic [3:0]      bit_idx;
    logic [7:0]      shreg;
    logic [4:0]      polls;
    t_status         st_last;
    logic [7:0]      rd_byte;

    // simulated slave behavior on the line
    int         dev_wait_lows;
    int         dev_pres_idx;
    logic [7:0] dev_rd_byte;
    bit         dev_noisy;

    owire_res_t pending_res[$];
    owire_res_t got_r, want_r;
    int         errors = 0;
    int         tick_count = 0;
    int         cycles = 0;
    int         rx_wait = 0;
    bit         tx_gaps = 1'b0;
    bit         rx_stalls = 1'b0;
    bit         busy_noise = 1'b0;

    function automatic logic [9:0] hold_ticks(input logic [9:0] n);
        return (n == 10'd0) ? 10'd0 : n - 10'd1;
    endfunction

    function automatic logic [9:0] wr_low_hold();
        return hold_ticks(shreg[bit_idx[2:0]] ? tcfg[REG_WR_ONE_LOW] : tcfg[REG_WR_ZERO_LOW]);
    endfunction

    function automatic int pick_gap(input bit on);
        int r;
        r = $urandom_range(0, 99);
        if (!on || r < 75) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic reset_model();
        tcfg[REG_RESET_LOW]   = RstResetLow;
        tcfg[REG_WR_ONE_LOW]  = {3'd0, RstWrOneLow};
        tcfg[REG_WR_ZERO_LOW] = {3'd0, RstWrZeroLow};
        tcfg[REG_SLOT_REC]    = {3'd0, RstSlotRec};
        tcfg[REG_RD_LOW]      = {3'd0, RstRdLow};
        tcfg[REG_RD_SAMPLE]   = {3'd0, RstRdSample};
        tcfg[REG_RD_TAIL]     = {3'd0, RstRdTail};
        tcfg[REG_PRES_INTV]   = {3'd0, RstPresIntv};
        ph      = PH_IDLE;
        tmr     = '0;
        bit_idx = '0;
        shreg   = '0;
        polls   = '0;
        st_last = ST_OK;
        rd_byte = '0;
    endtask

    task automatic end_cmd(input t_status st, inout logic fin);
        ph      = PH_IDLE;
        tmr     = '0;
        st_last = st;
        fin     = 1'b1;
    endtask

    // advances the shadow master by one tick and returns the tick's outputs
    task automatic step_bus(input t_cmd cmd, input logic [7:0] data, input logic lvl,
                            output owire_res_t res);
        logic fin;
        fin = 1'b0;
        if (ph == PH_IDLE) begin
            case (cmd)
                CMD_RESET: begin
                    ph  = PH_RST_LOW;
                    tmr = hold_ticks(tcfg[REG_RESET_LOW]);
                end
                CMD_WRITE: begin
                    shreg   = data;
                    bit_idx = '0;
                    ph      = PH_WR_LOW;
                    tmr     = wr_low_hold();
                end
                CMD_READ: begin
                    shreg   = '0;
                    bit_idx = '0;
                    ph      = PH_RD_LOW;
                    tmr     = hold_ticks(tcfg[REG_RD_LOW]);
                end
                default: ;
            endcase
        end else if (tmr != '0) begin
            tmr = tmr - 10'd1;
        end else begin
            case (ph)
                PH_RST_LOW: begin
                    ph    = PH_RST_WAIT;
                    polls = 5'(RELEASE_POLLS);
                end
                PH_RST_WAIT: begin
                    if (lvl) begin
                        ph    = PH_RST_PRES;
                        polls = '0;
                    end else if (polls == '0) begin
                        end_cmd(ST_STUCK, fin);
                    end else begin
                        polls = polls - 5'd1;
                        tmr   = hold_ticks(10'(RELEASE_POLL_TICKS));
                    end
                end
                PH_RST_PRES: begin
                    if (polls >= 5'(PRESENCE_SAMPLES)) begin
                        end_cmd(ST_NO_DEV, fin);
                    end else if (!lvl) begin
                        end_cmd(ST_PRESENCE, fin);
                    end else begin
                        polls = polls + 5'd1;
                        tmr   = hold_ticks(tcfg[REG_PRES_INTV]);
                    end
                end
                PH_WR_LOW: begin
                    ph  = PH_WR_REC;
                    tmr = hold_ticks(tcfg[REG_SLOT_REC]);
                end
                PH_WR_REC: begin
                    bit_idx = bit_idx + 4'd1;
                    if (bit_idx >= 4'd8) begin
                        end_cmd(ST_OK, fin);
                    end else begin
                        ph  = PH_WR_LOW;
                        tmr = wr_low_hold();
                    end
                end
                PH_RD_LOW: begin
                    ph  = PH_RD_WAIT;
                    tmr = hold_ticks(tcfg[REG_RD_SAMPLE]);
                end
                PH_RD_WAIT: begin
                    shreg   = {lvl, shreg[7:1]};
                    bit_idx = bit_idx + 4'd1;
                    ph      = PH_RD_TAIL;
                    tmr     = hold_ticks(tcfg[REG_RD_TAIL]);
                end
                PH_RD_TAIL: begin
                    if (bit_idx >= 4'd8) begin
                        rd_byte = shreg;
                        end_cmd(ST_OK, fin);
                    end else begin
                        ph  = PH_RD_LOW;
                        tmr = hold_ticks(tcfg[REG_RD_LOW]);
                    end
                end
                default: begin
                    ph  = PH_IDLE;
                    tmr = '0;
                end
            endcase
        end
        res.pad   = '0;
        res.rd    = rd_byte;
        res.st    = st_last;
        res.done  = fin;
        res.busy  = (ph != PH_IDLE);
        res.drive = (ph == PH_RST_LOW || ph == PH_WR_LOW || ph == PH_RD_LOW);
    endtask

    // line level the slave presents on the coming tick; only sampled ticks matter
    function automatic logic bus_line();
        if (!dev_noisy && tmr == '0) begin
            if (ph == PH_RST_WAIT) return (RELEASE_POLLS - int'(polls)) >= dev_wait_lows;
            if (ph == PH_RST_PRES) return int'(polls) != dev_pres_idx;
            if (ph == PH_RD_WAIT) return dev_rd_byte[bit_idx[2:0]];
        end
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_tick(input t_cmd cmd, input logic [7:0] data);
        int         gap;
        logic       lvl;
        owire_res_t res;
        lvl = bus_line();
        gap = pick_gap(tx_gaps);
        if (gap > 0) begin
            @(negedge i_clk) s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, lvl, data, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        step_bus(cmd, data, lvl, res);
        pending_res.push_back(res);
        tick_count++;
    endtask

    // issue a command and keep ticking until the master is idle again
    task automatic run_cmd(input t_cmd cmd, input logic [7:0] data);
        send_tick(cmd, data);
        while (ph != PH_IDLE) begin
            if (busy_noise && $urandom_range(0, 15) == 0)
                send_tick(t_cmd'($urandom_range(1, 3)), 8'($urandom));
            else
                send_tick(CMD_TICK, 8'($urandom));
        end
    endtask

    task automatic set_device(input int wait_lows, input int pres_idx, input logic [7:0] rd);
        dev_wait_lows = wait_lows;
        dev_pres_idx  = pres_idx;
        dev_rd_byte   = rd;
        dev_noisy     = 1'b0;
    endtask

    // stop the stream and wait for every pending result
    task automatic settle();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_timing(input logic [7:0][9:0] vals, input logic [7:0] mask);
        settle();
        for (int i = 0; i < 8; i++) begin
            if (mask[i]) begin
                @(negedge i_clk);
                i_cfg_we    <= 1'b1;
                i_cfg_index <= t_reg_idx'(i);
                i_cfg_data  <= vals[i];
                tcfg[i] = (i == REG_RESET_LOW) ? vals[i] : {3'd0, vals[i][6:0]};
            end
        end
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0][9:0] random_timing(input bit wide);
        logic [7:0][9:0] v;
        int              lo;
        for (int i = 0; i < 8; i++) begin
            if (i == REG_RESET_LOW) begin
                v[i] = wide ? 10'($urandom_range(1, 64)) : 10'($urandom_range(1, 12));
            end else begin
                lo = (i == REG_SLOT_REC || i == REG_RD_SAMPLE || i == REG_RD_TAIL) ? 0 : 1;
                v[i][6:0] = 7'($urandom_range(lo, wide ? 12 : 6));
                // upper bits are dropped for 7-bit registers
                v[i][9:7] = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom);
            end
        end
        return v;
    endfunction

    task automatic test_default_timing();
        logic [7:0][9:0] t;
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        set_device(1, 1, 8'h3C);
        run_cmd(CMD_TICK, 8'h00);
        run_cmd(CMD_WRITE, 8'h7F);
        // short bus reset low time and read slot, the other slot times stay at reset
        t = '0;
        t[REG_RESET_LOW] = 10'd3;
        t[REG_RD_SAMPLE] = 10'd2;
        t[REG_RD_TAIL]   = 10'd2;
        apply_timing(t, 8'h61);
        run_cmd(CMD_RESET, 8'hFF);
        run_cmd(CMD_READ, 8'h00);
    endtask

    task automatic test_bus_reset_cases();
        logic [7:0][9:0] t;
        t = '0;
        t[REG_RESET_LOW]   = 10'd1;
        t[REG_WR_ONE_LOW]  = 10'd1;
        t[REG_WR_ZERO_LOW] = 10'd2;
        t[REG_SLOT_REC]    = 10'd1;
        t[REG_RD_LOW]      = 10'd1;
        t[REG_RD_SAMPLE]   = 10'd1;
        t[REG_RD_TAIL]     = 10'd1;
        t[REG_PRES_INTV]   = 10'd1;
        apply_timing(t, 8'hFF);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        // line rises at once, presence on the first sample
        set_device(0, 0, 8'h00);
        run_cmd(CMD_RESET, 8'h00);
        // line rises on the last poll, presence on the last sample
        set_device(RELEASE_POLLS, PRESENCE_SAMPLES - 1, 8'h00);
        run_cmd(CMD_RESET, 8'h00);
        // line never rises
        set_device(RELEASE_POLLS + 1, 0, 8'h00);
        run_cmd(CMD_RESET, 8'h00);
        // no slave answers, with commands thrown at the busy master
        busy_noise = 1'b1;
        set_device(1, 31, 8'h00);
        run_cmd(CMD_RESET, 8'h00);
        busy_noise = 1'b0;
    endtask

    task automatic test_write_read_slots();
        logic [7:0][9:0] t;
        t = '0;
        t[REG_RESET_LOW]   = 10'd5;
        t[REG_WR_ONE_LOW]  = 10'd1;
        t[REG_WR_ZERO_LOW] = 10'd5;
        t[REG_SLOT_REC]    = 10'd0;
        t[REG_RD_LOW]      = 10'd1;
        t[REG_RD_SAMPLE]   = 10'd0;
        t[REG_RD_TAIL]     = 10'd0;
        t[REG_PRES_INTV]   = 10'd2;
        apply_timing(t, 8'hFF);
        set_device(0, 31, 8'hFF);
        run_cmd(CMD_WRITE, 8'h00);
        run_cmd(CMD_WRITE, 8'hFF);
        run_cmd(CMD_READ, 8'h00);
        set_device(0, 31, 8'h00);
        busy_noise = 1'b1;
        run_cmd(CMD_READ, 8'hFF);
        run_cmd(CMD_WRITE, 8'h81);
        busy_noise = 1'b0;
    endtask

    task automatic test_timing_extremes();
        logic [7:0][9:0] t;
        // 7-bit registers with only upper bits set read as zero counts
        t = {8{10'h380}};
        t[REG_RESET_LOW]  = 10'd2;
        t[REG_WR_ONE_LOW] = 10'h3A0;
        apply_timing(t, 8'hFF);
        set_device(5, 2, 8'h96);
        run_cmd(CMD_RESET, 8'h00);
        run_cmd(CMD_WRITE, 8'h01);
        run_cmd(CMD_READ, 8'h00);
    endtask

    task automatic test_random_traffic();
        int   stop_at;
        int   r;
        t_cmd c;
        stop_at    = tick_count + 200;
        busy_noise = 1'b1;
        while (tick_count < stop_at) begin
            apply_timing(random_timing($urandom_range(0, 5) == 0),
                         ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'hFF);
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(4, 10)) begin
                if (tick_count >= stop_at) break;
                r = $urandom_range(0, 9);
                dev_wait_lows = (r < 6) ? $urandom_range(0, 3) :
                                (r < 8) ? $urandom_range(4, RELEASE_POLLS) : RELEASE_POLLS + 1;
                dev_pres_idx  = ($urandom_range(0, 3) == 0) ? 31 :
                                $urandom_range(0, PRESENCE_SAMPLES - 1);
                dev_rd_byte   = 8'($urandom);
                dev_noisy     = ($urandom_range(0, 9) == 0);
                c = ($urandom_range(0, 7) == 0) ? CMD_TICK : t_cmd'($urandom_range(1, 3));
                run_cmd(c, 8'($urandom));
                if ($urandom_range(0, 15) == 0) settle();
            end
        end
        busy_noise = 1'b0;
    endtask

    initial begin
        reset_model();
        set_device(0, 0, 8'h00);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        test_default_timing();
        test_bus_reset_cases();
        test_write_read_slots();
        test_timing_extremes();
        test_random_traffic();
        settle();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending_res.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        if (rx_wait > 0) begin
            rx_wait--;
        end else begin
            rx_wait = pick_gap(rx_stalls);
            m_axis_tready <= (rx_wait == 0);
            if (rx_wait > 0) rx_wait--;
        end
    end

    task automatic check_field(input string what, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            if (errors <= 50)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_r = m_axis_tdata;
            if (pending_res.size() == 0) begin
                errors++;
                if (errors <= 50)
                    $display("%0t: unexpected transaction, expected none, actual %h",
                             $time, m_axis_tdata);
            end else begin
                want_r = pending_res.pop_front();
                check_field("drive_low", 8'(want_r.drive), 8'(got_r.drive));
                check_field("busy", 8'(want_r.busy), 8'(got_r.busy));
                check_field("done", 8'(want_r.done), 8'(got_r.done));
                check_field("status", 8'(want_r.st), 8'(got_r.st));
                check_field("read_value", want_r.rd, got_r.rd);
                check_field("pad", 8'(want_r.pad), 8'(got_r.pad));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
